// ----- sv/ddd_pkg.sv -----
// Shared widths, constants and the month table for the date difference block.
`timescale 1ns / 1ps
package ddd_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonW   = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned DistW  = 22;
  localparam int unsigned NumW   = 23;
  localparam int unsigned PartW  = 10;
  localparam int unsigned QuotW  = 8;

  // floor(p / 100) = (p * Recip100) >> Recip100Sh, exact for 14-bit p
  localparam int unsigned Recip100W  = 13;
  localparam int unsigned Recip100Sh = 19;
  localparam logic [Recip100W-1:0] Recip100 = 13'd5243;

  localparam logic [NumW-1:0]  YearZeroDays = 23'd366;
  localparam logic [YearW-1:0] CentRemLast  = 14'd99;
  localparam logic [MonW-1:0]  MonMarch     = 4'd3;
  localparam logic [DistW-1:0] DistMax      = '1;

  typedef logic [NumW-1:0] day_num_t;

  function automatic logic [PartW-1:0] days_before_month(input logic [MonW-1:0] m);
    logic [PartW-1:0] r;
    case (m)
      4'd0:    r = 10'd0;
      4'd1:    r = 10'd0;
      4'd2:    r = 10'd31;
      4'd3:    r = 10'd59;
      4'd4:    r = 10'd90;
      4'd5:    r = 10'd120;
      4'd6:    r = 10'd151;
      4'd7:    r = 10'd181;
      4'd8:    r = 10'd212;
      4'd9:    r = 10'd243;
      4'd10:   r = 10'd273;
      4'd11:   r = 10'd304;
      4'd12:   r = 10'd334;
      default: r = 10'd365;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/ddd_if.sv -----
// Request and result channel interfaces.
`timescale 1ns / 1ps
interface ddd_in_if;
  import ddd_pkg::*;
  logic             valid;
  logic             ready;
  logic [DayW-1:0]  day_first;
  logic [MonW-1:0]  month_first;
  logic [YearW-1:0] year_first;
  logic [DayW-1:0]  day_second;
  logic [MonW-1:0]  month_second;
  logic [YearW-1:0] year_second;

  modport source (output valid, day_first, month_first, year_first,
                  day_second, month_second, year_second, input ready);
  modport sink (input valid, day_first, month_first, year_first,
                day_second, month_second, year_second, output ready);
endinterface

interface ddd_out_if;
  import ddd_pkg::*;
  logic             valid;
  logic             ready;
  logic [DistW-1:0] day_distance;

  modport source (output valid, day_distance, input ready);
  modport sink (input valid, day_distance, output ready);
endinterface

// ----- sv/ddd_day_num.sv -----
// Three-stage day number pipeline for one date.
`timescale 1ns / 1ps
module ddd_day_num import ddd_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DayW-1:0]  day_i,
  input  logic [MonW-1:0]  month_i,
  input  logic [YearW-1:0] year_i,
  output day_num_t         num_o
);

  // stage 1: year minus one, its century count, month offset plus day
  logic [YearW-1:0]                p_d, p1_q;
  logic [YearW+Recip100W-1:0]      prod;
  logic [QuotW-1:0]                q_d, q1_q;
  logic [PartW-1:0]                part_d, part1_q, part2_q;
  logic                            yz1_q, post1_q, post2_q;

  // stage 2: year days and leap flag
  logic [YearW-1:0]                rem;
  logic [NumW-1:0]                 yb_d, yb2_q;
  logic [QuotW-1:0]                qc_d, qc2_q;
  logic                            leap_d, leap2_q, yz2_q;
  day_num_t                        num_d, num_q;

  assign p_d    = year_i - YearW'(1);
  assign prod   = (YearW+Recip100W)'(p_d) * (YearW+Recip100W)'(Recip100);
  assign q_d    = prod[Recip100Sh +: QuotW];
  assign part_d = days_before_month(month_i) + PartW'(day_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q    <= p_d;
      q1_q    <= q_d;
      part1_q <= part_d;
      yz1_q   <= (year_i == '0);
      post1_q <= (month_i >= MonMarch);
    end
  end

  assign rem    = p1_q - YearW'(q1_q) * YearW'(100);
  assign yb_d   = YearZeroDays + NumW'(p1_q) * NumW'(365) + NumW'(p1_q >> 2);
  assign qc_d   = q1_q - (q1_q >> 2);
  assign leap_d = yz1_q || ((p1_q[1:0] == 2'd3) &&
                  !((rem == CentRemLast) && (q1_q[1:0] != 2'd3)));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      yb2_q   <= yb_d;
      qc2_q   <= qc_d;
      leap2_q <= leap_d;
      yz2_q   <= yz1_q;
      part2_q <= part1_q;
      post2_q <= post1_q;
    end
  end

  always_comb begin
    num_d = NumW'(part2_q) + NumW'(post2_q && leap2_q);
    if (!yz2_q) begin
      num_d = num_d + yb2_q - NumW'(qc2_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= num_d;
    end
  end

  assign num_o = num_q;

endmodule

// ----- sv/date_difference_days.sv -----
// Throughput: one date pair per cycle; a stalled output freezes the whole pipeline.
// Stages: year split and century count, year days and leap, day number, distance.
// Reset clears only the stage valid bits; data registers are not reset.
// No clearing pass; requests are taken from the first cycle after reset.
`timescale 1ns / 1ps
module date_difference_days import ddd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  ddd_in_if.sink    in_i,
  ddd_out_if.source out_o
);

  logic [3:0]       vld_q, vld_d;
  logic             en;
  day_num_t         num_a, num_b;
  logic [NumW-1:0]  diff;
  logic [DistW-1:0] dist_d, dist_q;

  assign en         = !vld_q[3] || out_o.ready;
  assign in_i.ready = en;
  assign vld_d      = {vld_q[2:0], in_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  ddd_day_num u_first (
    .clk_i   (clk_i),
    .en_i    (en),
    .day_i   (in_i.day_first),
    .month_i (in_i.month_first),
    .year_i  (in_i.year_first),
    .num_o   (num_a)
  );

  ddd_day_num u_second (
    .clk_i   (clk_i),
    .en_i    (en),
    .day_i   (in_i.day_second),
    .month_i (in_i.month_second),
    .year_i  (in_i.year_second),
    .num_o   (num_b)
  );

  assign diff   = (num_a > num_b) ? (num_a - num_b) : (num_b - num_a);
  assign dist_d = diff[NumW-1] ? DistMax : diff[DistW-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q <= dist_d;
    end
  end

  assign out_o.valid        = vld_q[3];
  assign out_o.day_distance = dist_q;

`ifndef SYNTHESIS
  a_req_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> vld_q[0])
    else $error("accepted request did not enter stage 1");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("valid bits moved during stall");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && vld_q[2]) |=> vld_q[3])
    else $error("item lost between stage 3 and output");

  a_no_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[3] && !out_o.ready) |-> !in_i.ready)
    else $error("request taken while output stalled");
`endif

endmodule

// ----- test/tb_date_difference_days.sv -----
// Self-checking testbench for the date difference block: directed and random date pairs.
`timescale 1ns / 1ps

typedef struct packed {
  logic [ddd_pkg::DayW-1:0]  day_a;
  logic [ddd_pkg::MonW-1:0]  month_a;
  logic [ddd_pkg::YearW-1:0] year_a;
  logic [ddd_pkg::DayW-1:0]  day_b;
  logic [ddd_pkg::MonW-1:0]  month_b;
  logic [ddd_pkg::YearW-1:0] year_b;
} date_pair_t;

class distance_scoreboard;
  logic [ddd_pkg::DistW-1:0] expected_q[$];
  int unsigned               errors;
  int unsigned               checked;
  int unsigned               requests;
  int unsigned               saturated;

  function new();
    errors    = 0;
    checked   = 0;
    requests  = 0;
    saturated = 0;
  endfunction

  // Days since the start of year zero; fields are taken at their full widths.
  function automatic longint unsigned day_count(logic [ddd_pkg::DayW-1:0] d,
                                                logic [ddd_pkg::MonW-1:0] m,
                                                logic [ddd_pkg::YearW-1:0] y);
    longint unsigned prior;
    longint unsigned total;
    longint unsigned month_days;
    bit              leap;
    prior = 0;
    total = 0;
    if (y != 0) begin
      prior = longint'(y) - 1;
      total = 366 + 365 * prior + prior / 4 - prior / 100 + prior / 400;
    end
    case (m)
      4'd0, 4'd1: month_days = 0;
      4'd2:       month_days = 31;
      4'd3:       month_days = 59;
      4'd4:       month_days = 90;
      4'd5:       month_days = 120;
      4'd6:       month_days = 151;
      4'd7:       month_days = 181;
      4'd8:       month_days = 212;
      4'd9:       month_days = 243;
      4'd10:      month_days = 273;
      4'd11:      month_days = 304;
      4'd12:      month_days = 334;
      default:    month_days = 365;
    endcase
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    if (m >= 3 && leap) month_days++;
    return total + month_days + d;
  endfunction

  function void note_pair(date_pair_t p);
    longint unsigned a;
    longint unsigned b;
    longint unsigned gap;
    a = day_count(p.day_a, p.month_a, p.year_a);
    b = day_count(p.day_b, p.month_b, p.year_b);
    gap = (a > b) ? a - b : b - a;
    if (gap > 64'd4194303) begin
      gap = 64'd4194303;
      saturated++;
    end
    expected_q.push_back(gap[ddd_pkg::DistW-1:0]);
    requests++;
  endfunction

  function void check_distance(logic [ddd_pkg::DistW-1:0] actual);
    logic [ddd_pkg::DistW-1:0] exp_dist;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result: day_distance %0d", actual);
      return;
    end
    exp_dist = expected_q.pop_front();
    checked++;
    if (actual !== exp_dist) begin
      errors++;
      if (errors <= 10)
        $display("day_distance wrong at result %0d: expected %0d, got %0d",
                 checked, exp_dist, actual);
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_date_difference_days;
  import ddd_pkg::*;

  localparam int unsigned ItemsPerPhase = 258;

  logic clk_i = 1'b0;
  logic rst_ni;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  distance_scoreboard sb;

  ddd_in_if  req_if ();
  ddd_out_if res_if ();

  date_difference_days i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (res_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    res_if.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      sb.check_distance(res_if.day_distance);
    end
  end

  initial begin
    #5_000_000;
    $display("date_difference_days: mismatch");
    $finish;
  end

  function automatic date_pair_t make_pair(int d1, int m1, int y1, int d2, int m2, int y2);
    date_pair_t p;
    p.day_a   = d1[DayW-1:0];
    p.month_a = m1[MonW-1:0];
    p.year_a  = y1[YearW-1:0];
    p.day_b   = d2[DayW-1:0];
    p.month_b = m2[MonW-1:0];
    p.year_b  = y2[YearW-1:0];
    return p;
  endfunction

  function automatic date_pair_t random_pair();
    int unsigned kind;
    int unsigned y1;
    int unsigned y2;
    kind = $urandom_range(99);
    y1 = $urandom_range(9999, 1);
    y2 = $urandom_range(9999, 1);
    if (kind < 12) begin
      // raw fields: day zero, month zero and above twelve, years past 9999
      return make_pair($urandom_range(31), $urandom_range(15), $urandom_range(16383),
                       $urandom_range(31), $urandom_range(15), $urandom_range(16383));
    end
    if (kind < 40) begin
      // nearby years, short distances across leap boundaries
      y2 = (y1 > 9995) ? y1 - $urandom_range(3) : y1 + $urandom_range(3);
    end else if (kind < 45) begin
      y1 = $urandom_range(16383, 9000);
      y2 = $urandom_range(500);
    end
    return make_pair($urandom_range(31, 1), $urandom_range(12, 1), y1,
                     $urandom_range(31, 1), $urandom_range(12, 1), y2);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_pair(input date_pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid        = 1'b1;
    req_if.day_first    = p.day_a;
    req_if.month_first  = p.month_a;
    req_if.year_first   = p.year_a;
    req_if.day_second   = p.day_b;
    req_if.month_second = p.month_b;
    req_if.year_second  = p.year_b;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
    sb.note_pair(p);
    @(negedge clk_i);
  endtask

  task automatic drain();
    req_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  initial begin
    date_pair_t directed[$];
    sb = new();
    rst_ni              = 1'b0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    req_if.valid        = 1'b0;
    req_if.day_first    = '0;
    req_if.month_first  = '0;
    req_if.year_first   = '0;
    req_if.day_second   = '0;
    req_if.month_second = '0;
    req_if.year_second  = '0;
    res_if.ready        = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    directed.push_back(make_pair(0, 0, 0, 0, 0, 0));
    directed.push_back(make_pair(1, 1, 1, 31, 12, 9999));
    directed.push_back(make_pair(31, 12, 9999, 1, 1, 1));
    directed.push_back(make_pair(15, 6, 2024, 15, 6, 2024));
    directed.push_back(make_pair(29, 2, 2024, 1, 3, 2024));
    directed.push_back(make_pair(28, 2, 1900, 1, 3, 1900));
    directed.push_back(make_pair(28, 2, 2000, 1, 3, 2000));
    directed.push_back(make_pair(1, 1, 2000, 1, 1, 2001));
    directed.push_back(make_pair(31, 4, 2023, 1, 5, 2023));
    directed.push_back(make_pair(0, 3, 2023, 28, 2, 2023));
    directed.push_back(make_pair(10, 0, 2023, 10, 1, 2023));
    directed.push_back(make_pair(5, 13, 2023, 5, 1, 2024));
    directed.push_back(make_pair(5, 15, 2024, 5, 13, 2024));
    directed.push_back(make_pair(1, 1, 0, 1, 1, 1));
    directed.push_back(make_pair(31, 15, 0, 0, 0, 0));
    directed.push_back(make_pair(31, 15, 16383, 0, 0, 0));
    directed.push_back(make_pair(0, 0, 0, 31, 15, 16383));
    directed.push_back(make_pair(1, 1, 11483, 1, 1, 1));
    directed.push_back(make_pair(1, 1, 11484, 1, 1, 0));
    directed.push_back(make_pair(31, 12, 8191, 1, 1, 8192));
    directed.push_back(make_pair(16, 8, 4096, 21, 7, 1024));
    foreach (directed[i]) send_pair(directed[i]);

    for (int phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      repeat (ItemsPerPhase) send_pair(random_pair());
    end

    drain();
    repeat (8) @(negedge clk_i);
    $display("covered %0d date pairs in four pacing phases, %0d at the saturation limit",
             sb.requests, sb.saturated);
    $display("%0d distances checked, %0d errors", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("date_difference_days: match");
    end else begin
      $display("date_difference_days: mismatch");
    end
    $finish;
  end

endmodule
